/* rtl/i2cmbe_pkg.sv */
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

	localparam int unsigned QueueDepth = 2;
	localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
	localparam logic [3:0]  BitsPerByte = 4'd8;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_START = 5'b00010,
		ST_STOP  = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_READ  = 5'b10000
	} op_state_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} res_t;

endpackage

/* rtl/i2cmbe_req_if.sv */
// ----------------------------------------------------------------------------
// i2cmbe_req_if
// Tick channel into the engine: command and sampled SDA for one bus phase.
// ----------------------------------------------------------------------------
interface i2cmbe_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] tx_byte;
	logic       send_ack;
	logic       sda_in;

	modport source (output valid, output command, output tx_byte, output send_ack,
		output sda_in, input ready);
	modport sink (input valid, input command, input tx_byte, input send_ack,
		input sda_in, output ready);
endinterface

/* rtl/i2cmbe_rsp_if.sv */
// ----------------------------------------------------------------------------
// i2cmbe_rsp_if
// Result channel out of the engine: line levels and status for one tick.
// ----------------------------------------------------------------------------
interface i2cmbe_rsp_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;

	modport source (output valid, output scl_level, output sda_level, output busy_res,
		output done_res, output rx_byte, output ack_seen, input ready);
	modport sink (input valid, input scl_level, input sda_level, input busy_res,
		input done_res, input rx_byte, input ack_seen, output ready);
endinterface

/* rtl/i2c_master_byte_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master engine stepping one bus phase per tick transaction.
//
// req carries one tick: command (start, stop, write, read; taken when idle),
// tx_byte, send_ack and the sampled SDA level. rsp returns one transaction per
// tick with the SCL/SDA levels to drive, busy, done, rx_byte and ack_seen.
// Start and stop take 3 ticks, a byte write or read takes 18 ticks.
// Each tick passes through the two-entry tick queue and then the output
// register that the sequencer fills before rsp.valid rises.
// Throughput is one tick per cycle while rsp does not stall.
// Reset leaves the engine idle with both lines released and rx_byte zero.
// When rsp stalls the output register holds; the queue still takes up to
// two more ticks before req.ready drops.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
	import i2cmbe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	i2cmbe_req_if.sink   req,
	i2cmbe_rsp_if.source rsp
);

	logic  q_valid;
	tick_t q_tick;
	logic  q_pop;

	i2cmbe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_tick  (q_tick),
		.q_pop   (q_pop)
	);

	i2cmbe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_tick  (q_tick),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

/* rtl/i2cmbe_front.sv */
// ----------------------------------------------------------------------------
// i2cmbe_front
// Accepts tick transactions, decodes the command code and queues the tick.
// ----------------------------------------------------------------------------
module i2cmbe_front
	import i2cmbe_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	i2cmbe_req_if.sink req,
	output logic   q_valid,
	output tick_t  q_tick,
	input  logic   q_pop
);

	tick_t                mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueueCntW-1:0] count_q;
	tick_t                tick_dec;
	logic                 push;

	always_comb begin
		tick_dec.tx_byte  = req.tx_byte;
		tick_dec.send_ack = req.send_ack;
		tick_dec.sda_in   = req.sda_in;
		case (req.command)
			CMD_START: tick_dec.cmd = CMD_START;
			CMD_STOP:  tick_dec.cmd = CMD_STOP;
			CMD_WRITE: tick_dec.cmd = CMD_WRITE;
			CMD_READ:  tick_dec.cmd = CMD_READ;
			default:   tick_dec.cmd = CMD_NONE;
		endcase
	end

	assign req.ready = (count_q != QueueCntW'(QueueDepth));
	assign push      = req.valid && req.ready;
	assign q_valid   = (count_q != '0);
	assign q_tick    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= tick_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0
					: wr_ptr_q + QueuePtrW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0
					: rd_ptr_q + QueuePtrW'(1);
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + QueueCntW'(1);
				2'b01:   count_q <= count_q - QueueCntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/i2cmbe_back.sv */
// ----------------------------------------------------------------------------
// i2cmbe_back
// Bus phase sequencer: runs one queued tick per cycle unless rsp stalls, and registers the result.
// ----------------------------------------------------------------------------
module i2cmbe_back
	import i2cmbe_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	input  tick_t  q_tick,
	output logic   q_pop,
	i2cmbe_rsp_if.source rsp
);

	op_state_t  op_q, op_n;
	logic [1:0] phase_q, phase_n;
	logic [3:0] bit_q, bit_n;
	logic [7:0] shift_q, shift_n;
	logic       scl_q, scl_n;
	logic       sda_q, sda_n;
	logic       ack_q, ack_n;
	logic       ats_q, ats_n;
	logic [7:0] rx_q, rx_n;
	logic       busy;
	logic       done;
	logic       out_valid_q;
	res_t       res_q;
	logic       more_bits;

	assign q_pop = q_valid && (!out_valid_q || rsp.ready);

	always_comb begin
		op_n    = op_q;
		phase_n = phase_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		ack_n   = ack_q;
		ats_n   = ats_q;
		rx_n    = rx_q;
		busy    = 1'b0;
		done    = 1'b0;

		if (op_q == ST_IDLE) begin
			phase_n = 2'd0;
			bit_n   = 4'd0;
			case (q_tick.cmd)
				CMD_START: op_n = ST_START;
				CMD_STOP:  op_n = ST_STOP;
				CMD_WRITE: begin
					op_n    = ST_WRITE;
					shift_n = q_tick.tx_byte;
				end
				CMD_READ: begin
					op_n    = ST_READ;
					shift_n = 8'd0;
					ats_n   = q_tick.send_ack;
				end
				default: ;
			endcase
		end

		more_bits = (bit_n < BitsPerByte);

		case (op_n)
			ST_START: begin
				busy = 1'b1;
				if (phase_n == 2'd0) begin
					sda_n = 1'b1; scl_n = 1'b1; phase_n = 2'd1;
				end else if (phase_n == 2'd1) begin
					sda_n = 1'b0; scl_n = 1'b1; phase_n = 2'd2;
				end else begin
					sda_n = 1'b0; scl_n = 1'b0; done = 1'b1;
				end
			end
			ST_STOP: begin
				busy = 1'b1;
				if (phase_n == 2'd0) begin
					sda_n = 1'b0; scl_n = 1'b0; phase_n = 2'd1;
				end else if (phase_n == 2'd1) begin
					sda_n = 1'b0; scl_n = 1'b1; phase_n = 2'd2;
				end else begin
					sda_n = 1'b1; scl_n = 1'b1; done = 1'b1;
				end
			end
			ST_WRITE: begin
				busy = 1'b1;
				if (phase_n == 2'd0) begin
					scl_n = 1'b1;
					if (more_bits) begin
						sda_n = shift_n[7];
					end else begin
						sda_n = 1'b1;
						ack_n = q_tick.sda_in;
					end
					phase_n = 2'd1;
				end else begin
					scl_n = 1'b0;
					if (more_bits) begin
						shift_n = {shift_n[6:0], 1'b0};
						bit_n   = bit_n + 4'd1;
						phase_n = 2'd0;
					end else begin
						done = 1'b1;
					end
				end
			end
			ST_READ: begin
				busy = 1'b1;
				if (phase_n == 2'd0) begin
					scl_n = 1'b1;
					if (more_bits) begin
						sda_n   = 1'b1;
						shift_n = {shift_n[6:0], q_tick.sda_in};
					end else begin
						sda_n = ~ats_n;
					end
					phase_n = 2'd1;
				end else begin
					scl_n = 1'b0;
					if (more_bits) begin
						bit_n   = bit_n + 4'd1;
						phase_n = 2'd0;
					end else begin
						rx_n = shift_n;
						done = 1'b1;
					end
				end
			end
			default: ;
		endcase

		if (done) begin
			op_n    = ST_IDLE;
			phase_n = 2'd0;
			bit_n   = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= ST_IDLE;
			phase_q     <= 2'd0;
			bit_q       <= 4'd0;
			shift_q     <= 8'd0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b1;
			ats_q       <= 1'b0;
			rx_q        <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				op_q        <= op_n;
				phase_q     <= phase_n;
				bit_q       <= bit_n;
				shift_q     <= shift_n;
				scl_q       <= scl_n;
				sda_q       <= sda_n;
				ack_q       <= ack_n;
				ats_q       <= ats_n;
				rx_q        <= rx_n;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.scl_level <= scl_n;
			res_q.sda_level <= sda_n;
			res_q.busy_res  <= busy;
			res_q.done_res  <= done;
			res_q.rx_byte   <= rx_n;
			res_q.ack_seen  <= ack_n;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.scl_level = res_q.scl_level;
	assign rsp.sda_level = res_q.sda_level;
	assign rsp.busy_res  = res_q.busy_res;
	assign rsp.done_res  = res_q.done_res;
	assign rsp.rx_byte   = res_q.rx_byte;
	assign rsp.ack_seen  = res_q.ack_seen;

endmodule

/* verif/i2c_master_byte_engine_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_tb
// Self-checking bench for the I2C master byte engine. Tick transactions go in
// with random gaps and results come out under random back-pressure. A
// scoreboard class steps its own copy of the bus-phase sequencer for every
// accepted tick and checks each result, field by field, in order. A short
// directed pass covers start, stop, byte writes and reads at the data
// extremes, unused command codes and commands issued while busy. The random
// pass issues mostly legal commands, with noise commands while busy.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_tb;
	import i2cmbe_pkg::*;

	localparam logic [2:0] CmdUnusedLo = 3'd5;
	localparam logic [2:0] CmdUnusedHi = 3'd7;
	localparam int         MaxWait     = 19;
	localparam int         TickTarget  = 1300;

	class i2c_phase_scoreboard;
		cmd_t       op;
		logic [1:0] phase;
		logic [3:0] bit_cnt;
		logic [7:0] shifter;
		logic       scl;
		logic       sda;
		logic       ack_sampled;
		logic       ack_drive;
		logic [7:0] rx_hold;
		res_t       expected_lines[$];
		int         errors;

		function new();
			op          = CMD_NONE;
			phase       = 2'd0;
			bit_cnt     = 4'd0;
			shifter     = 8'd0;
			scl         = 1'b1;
			sda         = 1'b1;
			ack_sampled = 1'b1;
			ack_drive   = 1'b0;
			rx_hold     = 8'd0;
			errors      = 0;
		endfunction

		function bit idle();
			return op == CMD_NONE;
		endfunction

		function int pending();
			return expected_lines.size();
		endfunction

		function bit takes(tick_t t);
			return op == CMD_NONE && t.cmd >= CMD_START && t.cmd <= CMD_READ;
		endfunction

		// step one bus phase and queue the result it produces
		function void note_tick(tick_t t);
			logic busy;
			logic fin;
			res_t r;
			busy = 1'b0;
			fin  = 1'b0;
			if (takes(t)) begin
				op      = t.cmd;
				phase   = 2'd0;
				bit_cnt = 4'd0;
				if (t.cmd == CMD_WRITE)
					shifter = t.tx_byte;
				if (t.cmd == CMD_READ) begin
					shifter   = 8'd0;
					ack_drive = t.send_ack;
				end
			end
			if (op != CMD_NONE) begin
				busy = 1'b1;
				case (op)
					CMD_START: begin
						if (phase == 2'd0) begin
							sda = 1'b1; scl = 1'b1; phase = 2'd1;
						end else if (phase == 2'd1) begin
							sda = 1'b0; scl = 1'b1; phase = 2'd2;
						end else begin
							sda = 1'b0; scl = 1'b0; fin = 1'b1;
						end
					end
					CMD_STOP: begin
						if (phase == 2'd0) begin
							sda = 1'b0; scl = 1'b0; phase = 2'd1;
						end else if (phase == 2'd1) begin
							sda = 1'b0; scl = 1'b1; phase = 2'd2;
						end else begin
							sda = 1'b1; scl = 1'b1; fin = 1'b1;
						end
					end
					CMD_WRITE: begin
						if (phase == 2'd0) begin
							scl = 1'b1;
							if (bit_cnt < BitsPerByte) begin
								sda = shifter[7];
							end else begin
								sda         = 1'b1;
								ack_sampled = t.sda_in;
							end
							phase = 2'd1;
						end else begin
							scl = 1'b0;
							if (bit_cnt < BitsPerByte) begin
								shifter = {shifter[6:0], 1'b0};
								bit_cnt = bit_cnt + 4'd1;
								phase   = 2'd0;
							end else begin
								fin = 1'b1;
							end
						end
					end
					default: begin
						if (phase == 2'd0) begin
							scl = 1'b1;
							if (bit_cnt < BitsPerByte) begin
								sda     = 1'b1;
								shifter = {shifter[6:0], t.sda_in};
							end else begin
								sda = ~ack_drive;
							end
							phase = 2'd1;
						end else begin
							scl = 1'b0;
							if (bit_cnt < BitsPerByte) begin
								bit_cnt = bit_cnt + 4'd1;
								phase   = 2'd0;
							end else begin
								rx_hold = shifter;
								fin     = 1'b1;
							end
						end
					end
				endcase
				if (fin) begin
					op      = CMD_NONE;
					phase   = 2'd0;
					bit_cnt = 4'd0;
				end
			end
			r.scl_level = scl;
			r.sda_level = sda;
			r.busy_res  = busy;
			r.done_res  = fin;
			r.rx_byte   = rx_hold;
			r.ack_seen  = ack_sampled;
			expected_lines.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task compare(string field, int got, int want);
			if (got != want)
				report($sformatf("%s got 0x%0h expected 0x%0h", field, got, want));
		endtask

		task check_result(res_t got);
			res_t want;
			if (expected_lines.size() == 0) begin
				report("result with no tick outstanding");
			end else begin
				want = expected_lines.pop_front();
				compare("scl_level", got.scl_level, want.scl_level);
				compare("sda_level", got.sda_level, want.sda_level);
				compare("busy_res", got.busy_res, want.busy_res);
				compare("done_res", got.done_res, want.done_res);
				compare("rx_byte", got.rx_byte, want.rx_byte);
				compare("ack_seen", got.ack_seen, want.ack_seen);
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	i2cmbe_req_if req_ch();
	i2cmbe_rsp_if rsp_ch();

	i2c_master_byte_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	i2c_phase_scoreboard sb = new();

	bit quiet[2];
	int run_left[2];
	int ticks_counted;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// side 0 is the tick sender, side 1 the result receiver
	function automatic int pick_wait(int side);
		if (run_left[side] == 0) begin
			quiet[side]    = ($urandom_range(0, 2) == 0);
			run_left[side] = $urandom_range(10, 60);
		end
		run_left[side]--;
		return quiet[side] ? 0 : $urandom_range(0, MaxWait);
	endfunction

	// entered and left at a falling edge
	task automatic send_tick(tick_t t);
		int gap;
		gap = pick_wait(0);
		if (sb.takes(t) || !sb.idle())
			ticks_counted++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.command  <= t.cmd;
		req_ch.tx_byte  <= t.tx_byte;
		req_ch.send_ack <= t.send_ack;
		req_ch.sda_in   <= t.sda_in;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_tick(t);
		@(negedge clk);
	endtask

	task automatic run_cmd(logic [2:0] c, logic [7:0] tx, logic ack, logic sda_lvl,
		logic [2:0] noise);
		tick_t t;
		t.cmd      = cmd_t'(c);
		t.tx_byte  = tx;
		t.send_ack = ack;
		t.sda_in   = sda_lvl;
		send_tick(t);
		t.cmd = cmd_t'(noise);
		while (!sb.idle())
			send_tick(t);
	endtask

	function automatic tick_t rand_tick();
		tick_t t;
		int unsigned r;
		t.tx_byte  = 8'($urandom);
		t.send_ack = 1'($urandom);
		t.sda_in   = 1'($urandom);
		r = $urandom_range(0, 9);
		if (sb.idle()) begin
			if (r < 8)
				t.cmd = cmd_t'($urandom_range(CMD_START, CMD_READ));
			else if (r == 8)
				t.cmd = CMD_NONE;
			else
				t.cmd = cmd_t'($urandom_range(CmdUnusedLo, CmdUnusedHi));
		end else begin
			if (r < 7)
				t.cmd = CMD_NONE;
			else
				t.cmd = cmd_t'($urandom_range(CMD_NONE, CmdUnusedHi));
		end
		return t;
	endfunction

	initial begin
		res_t got;
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = pick_wait(1);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got.scl_level = rsp_ch.scl_level;
			got.sda_level = rsp_ch.sda_level;
			got.busy_res  = rsp_ch.busy_res;
			got.done_res  = rsp_ch.done_res;
			got.rx_byte   = rsp_ch.rx_byte;
			got.ack_seen  = rsp_ch.ack_seen;
			sb.check_result(got);
			@(negedge clk);
		end
	end

	initial begin
		logic [2:0] c;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.command  = CMD_NONE;
		req_ch.tx_byte  = 8'd0;
		req_ch.send_ack = 1'b0;
		req_ch.sda_in   = 1'b0;
		ticks_counted   = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_cmd(CMD_NONE, 8'h00, 1'b0, 1'b0, CMD_NONE);
		for (c = CmdUnusedLo; c <= CmdUnusedHi && c >= CmdUnusedLo; c++)
			run_cmd(c, 8'hFF, 1'b1, 1'b1, CMD_NONE);
		run_cmd(CMD_START, 8'h00, 1'b0, 1'b1, CMD_STOP);
		run_cmd(CMD_WRITE, 8'hFF, 1'b0, 1'b1, CMD_START);
		run_cmd(CMD_WRITE, 8'h00, 1'b1, 1'b0, CMD_READ);
		run_cmd(CMD_WRITE, 8'hA5, 1'b0, 1'b0, CMD_NONE);
		run_cmd(CMD_READ, 8'h00, 1'b1, 1'b1, CMD_WRITE);
		run_cmd(CMD_READ, 8'hFF, 1'b0, 1'b0, CmdUnusedHi);
		run_cmd(CMD_STOP, 8'h5A, 1'b1, 1'b0, CMD_STOP);
		run_cmd(CMD_START, 8'h00, 1'b0, 1'b0, CMD_NONE);
		run_cmd(CMD_STOP, 8'h00, 1'b0, 1'b1, CMD_START);
		run_cmd(CMD_NONE, 8'h00, 1'b0, 1'b1, CMD_NONE);

		while (ticks_counted < TickTarget)
			send_tick(rand_tick());
		req_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report("expected results left over");
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TIMEOUT @%0t", $realtime);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
